// File: rtl/ttg_pkg.sv
// ttg_pkg: shared types, constants and the Q2.28 to Q2.14 rounding helper
// for the triangle tangent generator; no dependencies
package ttg_pkg;

  // unit vector component width, Q2.28 signed
  localparam int unsigned UW = 30;
  // tangent output width, Q2.14 signed
  localparam int unsigned QW = 16;
  // width of a dot-product term and of the cross term
  localparam int unsigned PW = 60;

  localparam logic [27:0] THR_RESET = 28'd268;
  localparam logic signed [UW-1:0] ONE_Q28 = 30'sd268435456;

  // which vector the normalize sequence is working on
  localparam logic [2:0] JOB_E1 = 3'd0;
  localparam logic [2:0] JOB_E2 = 3'd1;
  localparam logic [2:0] JOB_U1 = 3'd2;
  localparam logic [2:0] JOB_U2 = 3'd3;
  localparam logic [2:0] JOB_TG = 3'd4;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LOAD   = 13'b0000000000010,
    S_SHIFT  = 13'b0000000000100,
    S_SQMUL  = 13'b0000000001000,
    S_SQACC  = 13'b0000000010000,
    S_SQRT   = 13'b0000000100000,
    S_DIVLD  = 13'b0000001000000,
    S_DIV    = 13'b0000010000000,
    S_PMUL   = 13'b0000100000000,
    S_PACC   = 13'b0001000000000,
    S_DECIDE = 13'b0010000000000,
    S_PREP   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

  // magnitude rounded to nearest (ties away), sign restored, saturated
  function automatic logic [QW-1:0] to_q14(input logic signed [UW-1:0] v);
    logic [UW-1:0] m;
    logic [UW:0]   s;
    logic [16:0]   r;
    logic [QW-1:0] q;
    m = v[UW-1] ? UW'(-v) : UW'(v);
    s = {1'b0, m} + 31'd8192;
    r = s[UW:14];
    if (r > 17'd32768) r = 17'd32768;
    if (v[UW-1]) begin
      q = QW'(17'd0 - r);
    end else if (r > 17'd32767) begin
      q = 16'h7fff;
    end else begin
      q = r[QW-1:0];
    end
    return q;
  endfunction

endpackage

// File: rtl/triangle_tangent_generator.sv
// triangle_tangent_generator: per-triangle tangent from positions and texture
// coordinates, one shared multiplier and one shared sqrt/divide datapath
// depends on ttg_pkg
//
// the first and second vertex of a triangle are only held. the third runs
// five normalize passes (two position edges, two texture edges, cross
// term), each shifting the largest magnitude into [2^29, 2^30) one bit a
// cycle, then square, sqrt and divide; a zero vector gives a zero result.
// in between det and cross term products on the multiplier, then the tangent
// is picked; the normalize of the cross term is skipped when degenerate.
// throughput: one triangle at a time, input stalled until the three result
// transfers are done. reset clears control and sets the threshold thr_q to 268.
module triangle_tangent_generator #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned INDEX_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [27:0]                   cfg_wdata_i,
  // vertex input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [INDEX_WIDTH-1:0]        vertex_index_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [COORD_WIDTH-1:0] tex_s_i,
  input  logic signed [COORD_WIDTH-1:0] tex_t_i,
  // tangent output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [INDEX_WIDTH-1:0]        out_index_o,
  output logic signed [ttg_pkg::QW-1:0] tan_x_o,
  output logic signed [ttg_pkg::QW-1:0] tan_y_o,
  output logic signed [ttg_pkg::QW-1:0] tan_z_o,
  output logic                          degenerate_o,
  output logic                          last_o
);
  import ttg_pkg::*;

  // normalize working width: holds an edge magnitude or the cross term
  localparam int unsigned VW = (COORD_WIDTH + 2 > PW) ? COORD_WIDTH + 2 : PW;
  localparam int unsigned SE = VW - COORD_WIDTH;

  state_e state_q, state_d;

  logic [27:0] thr_q;
  logic [1:0]  vcnt_q;

  // held first two vertices and the closing vertex
  logic [INDEX_WIDTH-1:0] hidx_q [2];
  logic [COORD_WIDTH-1:0] hpos_q [2][3];
  logic [COORD_WIDTH-1:0] htex_q [2][2];
  logic [INDEX_WIDTH-1:0] cidx_q;
  logic [COORD_WIDTH-1:0] cpos_q [3];
  logic [COORD_WIDTH-1:0] ctex_q [2];

  // normalize datapath
  logic [2:0]    job_q;
  logic [1:0]    c_q;
  logic [VW-1:0] mag_q [3];
  logic          neg_q [3];
  logic [VW-1:0] mx_q;
  logic [61:0]   sum_q;
  logic [61:0]   x_q;
  logic [63:0]   res_q;
  logic [63:0]   bit_q;
  logic [PW-1:0] num_q;
  logic [PW-1:0] dv_q;
  logic [27:0]   quo_q;
  logic [4:0]    kc_q;

  // unit vectors: e1, e2, u1, u2, tangent
  logic signed [UW-1:0] unit_q [5][3];

  // shared multiplier
  logic signed [UW:0]   mul_a, mul_b;
  logic signed [61:0]   prod_q;
  logic [2:0]           m_q;
  logic signed [PW-1:0] acc_q;
  logic signed [PW-1:0] det_q;
  logic signed [PW-1:0] nv_q [3];

  // result
  logic          degen_q;
  logic [QW-1:0] tq_q [3];
  logic [1:0]    ocnt_q;

  logic          in_xfer;
  logic [VW-1:0] vload [3];
  logic [VW-1:0] mload [3];
  logic          nload [3];
  logic [VW-1:0] mx_load;
  logic          in_range;
  logic          mx_zero;
  logic [63:0]   sq_try;
  logic          sq_ge;
  logic          div_ge;
  logic [UW-1:0] quo_fin;
  logic signed [PW-1:0] pdiff;
  logic [PW-1:0] adet;
  logic          degen;
  logic signed [UW-1:0] tsel [3];
  state_e        job_done;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // vector for the current job, sign-extended edges or the cross term
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vload[i] = '0;
    end
    case (job_q)
      JOB_E1: begin
        for (int i = 0; i < 3; i++) begin
          vload[i] = {{SE{hpos_q[1][i][COORD_WIDTH-1]}}, hpos_q[1][i]}
                   - {{SE{hpos_q[0][i][COORD_WIDTH-1]}}, hpos_q[0][i]};
        end
      end
      JOB_E2: begin
        for (int i = 0; i < 3; i++) begin
          vload[i] = {{SE{cpos_q[i][COORD_WIDTH-1]}}, cpos_q[i]}
                   - {{SE{hpos_q[0][i][COORD_WIDTH-1]}}, hpos_q[0][i]};
        end
      end
      JOB_U1: begin
        for (int i = 0; i < 2; i++) begin
          vload[i] = {{SE{htex_q[1][i][COORD_WIDTH-1]}}, htex_q[1][i]}
                   - {{SE{htex_q[0][i][COORD_WIDTH-1]}}, htex_q[0][i]};
        end
      end
      JOB_U2: begin
        for (int i = 0; i < 2; i++) begin
          vload[i] = {{SE{ctex_q[i][COORD_WIDTH-1]}}, ctex_q[i]}
                   - {{SE{htex_q[0][i][COORD_WIDTH-1]}}, htex_q[0][i]};
        end
      end
      JOB_TG: begin
        for (int i = 0; i < 3; i++) begin
          vload[i] = VW'(nv_q[i]);
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          vload[i] = '0;
        end
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      nload[i] = vload[i][VW-1];
      mload[i] = nload[i] ? (~vload[i] + VW'(1)) : vload[i];
    end
    mx_load = mload[0];
    if (mload[1] > mx_load) mx_load = mload[1];
    if (mload[2] > mx_load) mx_load = mload[2];
  end

  assign mx_zero  = (mx_q == '0);
  assign in_range = (mx_q[VW-1:30] == '0) && mx_q[29];

  // sqrt step, one result bit a cycle
  assign sq_try = res_q + bit_q;
  assign sq_ge  = ({2'b00, x_q} >= sq_try);

  // restoring divide step, one quotient bit a cycle
  assign div_ge  = (num_q >= dv_q);
  assign quo_fin = {1'b0, quo_q, div_ge};

  // multiplier operand select: squares, then det and cross term products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQMUL: begin
        mul_a = {1'b0, mag_q[c_q][UW-1:0]};
        mul_b = {1'b0, mag_q[c_q][UW-1:0]};
      end
      S_PMUL: begin
        case (m_q)
          3'd0: begin
            mul_a = {unit_q[2][0][UW-1], unit_q[2][0]};
            mul_b = {unit_q[3][1][UW-1], unit_q[3][1]};
          end
          3'd1: begin
            mul_a = {unit_q[2][1][UW-1], unit_q[2][1]};
            mul_b = {unit_q[3][0][UW-1], unit_q[3][0]};
          end
          3'd2: begin
            mul_a = {unit_q[3][1][UW-1], unit_q[3][1]};
            mul_b = {unit_q[0][0][UW-1], unit_q[0][0]};
          end
          3'd3: begin
            mul_a = {unit_q[2][1][UW-1], unit_q[2][1]};
            mul_b = {unit_q[1][0][UW-1], unit_q[1][0]};
          end
          3'd4: begin
            mul_a = {unit_q[3][1][UW-1], unit_q[3][1]};
            mul_b = {unit_q[0][1][UW-1], unit_q[0][1]};
          end
          3'd5: begin
            mul_a = {unit_q[2][1][UW-1], unit_q[2][1]};
            mul_b = {unit_q[1][1][UW-1], unit_q[1][1]};
          end
          3'd6: begin
            mul_a = {unit_q[3][1][UW-1], unit_q[3][1]};
            mul_b = {unit_q[0][2][UW-1], unit_q[0][2]};
          end
          3'd7: begin
            mul_a = {unit_q[2][1][UW-1], unit_q[2][1]};
            mul_b = {unit_q[1][2][UW-1], unit_q[1][2]};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign pdiff = acc_q - prod_q[PW-1:0];

  // degenerate when |det| is under threshold, det is zero or the cross
  // term vanishes
  assign adet  = det_q[PW-1] ? PW'(-det_q) : PW'(det_q);
  assign degen = (adet < {4'b0000, thr_q, 28'b0}) || (det_q == '0) ||
                 ((nv_q[0] == '0) && (nv_q[1] == '0) && (nv_q[2] == '0));

  // final tangent, default axis when degenerate, flipped for negative det
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (degen_q) begin
        tsel[i] = (i == 0) ? ONE_Q28 : '0;
      end else if (det_q[PW-1]) begin
        tsel[i] = -unit_q[4][i];
      end else begin
        tsel[i] = unit_q[4][i];
      end
    end
  end

  // where to go after a normalize pass finishes
  always_comb begin
    case (job_q)
      JOB_U2:  job_done = S_PMUL;
      JOB_TG:  job_done = S_PREP;
      default: job_done = S_LOAD;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && vcnt_q == 2'd2) state_d = S_LOAD;
      end
      S_LOAD: begin
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (mx_zero) begin
          state_d = job_done;
        end else if (in_range) begin
          state_d = S_SQMUL;
        end
      end
      S_SQMUL: begin
        state_d = S_SQACC;
      end
      S_SQACC: begin
        state_d = (c_q == 2'd2) ? S_SQRT : S_SQMUL;
      end
      S_SQRT: begin
        if (bit_q[0]) state_d = S_DIVLD;
      end
      S_DIVLD: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (kc_q == '0) state_d = (c_q == 2'd2) ? job_done : S_DIVLD;
      end
      S_PMUL: begin
        state_d = S_PACC;
      end
      S_PACC: begin
        state_d = (m_q == 3'd7) ? S_DECIDE : S_PMUL;
      end
      S_DECIDE: begin
        state_d = degen ? S_PREP : S_LOAD;
      end
      S_PREP: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i && ocnt_q == 2'd2) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      thr_q   <= THR_RESET;
      vcnt_q  <= '0;
      ocnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (in_xfer) vcnt_q <= (vcnt_q == 2'd2) ? 2'd0 : vcnt_q + 2'd1;
      if (state_q == S_OUT && !out_stall_i) begin
        ocnt_q <= (ocnt_q == 2'd2) ? 2'd0 : ocnt_q + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (vcnt_q != 2'd2) begin
            hidx_q[vcnt_q[0]]    <= vertex_index_i;
            hpos_q[vcnt_q[0]][0] <= pos_x_i;
            hpos_q[vcnt_q[0]][1] <= pos_y_i;
            hpos_q[vcnt_q[0]][2] <= pos_z_i;
            htex_q[vcnt_q[0]][0] <= tex_s_i;
            htex_q[vcnt_q[0]][1] <= tex_t_i;
          end else begin
            cidx_q    <= vertex_index_i;
            cpos_q[0] <= pos_x_i;
            cpos_q[1] <= pos_y_i;
            cpos_q[2] <= pos_z_i;
            ctex_q[0] <= tex_s_i;
            ctex_q[1] <= tex_t_i;
            job_q     <= JOB_E1;
          end
        end
      end
      S_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= mload[i];
          neg_q[i] <= nload[i];
        end
        mx_q <= mx_load;
      end
      S_SHIFT: begin
        if (mx_zero) begin
          for (int i = 0; i < 3; i++) begin
            unit_q[job_q][i] <= '0;
          end
          if (job_q == JOB_U2) begin
            m_q <= '0;
          end else if (job_q != JOB_TG) begin
            job_q <= job_q + 3'd1;
          end
        end else if (in_range) begin
          c_q   <= '0;
          sum_q <= '0;
        end else if (mx_q[VW-1:30] != '0) begin
          // truncating right shift, one bit a cycle
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
          mx_q <= mx_q >> 1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] << 1;
          end
          mx_q <= mx_q << 1;
        end
      end
      S_SQMUL: begin
        prod_q <= mul_a * mul_b;
      end
      S_SQACC: begin
        sum_q <= sum_q + prod_q;
        if (c_q == 2'd2) begin
          x_q   <= sum_q + prod_q;
          res_q <= '0;
          bit_q <= 64'h4000_0000_0000_0000;
          c_q   <= '0;
        end else begin
          c_q <= c_q + 2'd1;
        end
      end
      S_SQRT: begin
        if (sq_ge) begin
          x_q   <= x_q - sq_try[61:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DIVLD: begin
        num_q <= {2'b00, mag_q[c_q][UW-1:0], 28'b0};
        dv_q  <= {res_q[31:0], 28'b0};
        quo_q <= '0;
        kc_q  <= 5'd28;
      end
      S_DIV: begin
        if (div_ge) num_q <= num_q - dv_q;
        dv_q  <= dv_q >> 1;
        quo_q <= {quo_q[26:0], div_ge};
        kc_q  <= kc_q - 5'd1;
        if (kc_q == '0) begin
          unit_q[job_q][c_q] <= neg_q[c_q] ? -$signed(quo_fin) : $signed(quo_fin);
          if (c_q == 2'd2) begin
            if (job_q == JOB_U2) begin
              m_q <= '0;
            end else if (job_q != JOB_TG) begin
              job_q <= job_q + 3'd1;
            end
          end else begin
            c_q <= c_q + 2'd1;
          end
        end
      end
      S_PMUL: begin
        prod_q <= mul_a * mul_b;
      end
      S_PACC: begin
        // even steps open a term, odd steps close it
        if (!m_q[0]) begin
          acc_q <= prod_q[PW-1:0];
        end else if (m_q == 3'd1) begin
          det_q <= pdiff;
        end else begin
          nv_q[m_q[2:1] - 2'd1] <= pdiff;
        end
        m_q <= m_q + 3'd1;
      end
      S_DECIDE: begin
        degen_q <= degen;
        job_q   <= JOB_TG;
      end
      S_PREP: begin
        for (int i = 0; i < 3; i++) begin
          tq_q[i] <= to_q14(tsel[i]);
        end
      end
      default: begin
      end
    endcase
  end

  // three transfers per triangle: first held, second held, closing vertex
  assign out_valid_o  = (state_q == S_OUT);
  assign out_index_o  = (ocnt_q == 2'd0) ? hidx_q[0] :
                        (ocnt_q == 2'd1) ? hidx_q[1] : cidx_q;
  assign tan_x_o      = tq_q[0];
  assign tan_y_o      = tq_q[1];
  assign tan_z_o      = tq_q[2];
  assign degenerate_o = degen_q;
  assign last_o       = (ocnt_q == 2'd2);

endmodule
